/* sv/bts_pkg.sv */
// Package for the byte to sector request splitter.
// Holds the item, state and result types, the codes and the step functions.
// No dependencies.
package bts_pkg;

    localparam int SECTOR_BYTES  = 512;
    localparam int SECTOR_SHIFT  = 9;
    localparam int MAX_SECTORS   = 255;
    localparam int LBA_W         = 23;
    localparam int COUNT_W       = 8;
    localparam int SOFS_W        = 9;
    localparam int CHUNK_W       = 10;
    localparam int PEND_W        = 17;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_DISK_PRESENT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SECTORS = 1'd1;

    localparam logic CMD_REQUEST    = 1'b0;
    localparam logic CMD_COMPLETION = 1'b1;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FULL   = 2'd1,
        PH_SREAD  = 2'd2,
        PH_SWRITE = 2'd3
    } phase_t;

    typedef struct packed {
        logic        cmd;
        logic        is_write;
        logic [31:0] byte_offset;
        logic [31:0] byte_length;
        logic        status_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [LBA_W-1:0]   lba;
        logic [COUNT_W-1:0] sector_count;
        logic [31:0]        buffer_offset;
        logic [SOFS_W-1:0]  sector_offset;
        logic [CHUNK_W-1:0] chunk_bytes;
        logic               staged;
        logic [31:0]        bytes_done;
    } out_item_t;

    // pos is start offset plus bytes done; rem is clamped length minus bytes done
    typedef struct packed {
        phase_t            phase;
        logic              writing;
        logic [31:0]       pos;
        logic [31:0]       rem;
        logic [31:0]       done;
        logic [PEND_W-1:0] pend;
    } state_t;

    typedef struct packed {
        logic             disk_present;
        logic [LBA_W-1:0] total_sectors;
    } cfg_t;

    typedef struct packed {
        out_item_t         res;
        phase_t            phase;
        logic [PEND_W-1:0] pend;
    } step_t;

    function automatic step_t finish_step(input logic [31:0] done);
        step_t s;
        s = '0;
        s.res.op         = OP_FINISH;
        s.res.bytes_done = done;
        s.phase          = PH_IDLE;
        s.pend           = '0;
        return s;
    endfunction

    // Next command at the current position: multi-sector when aligned with at
    // least one full sector left, otherwise a staged one-sector read.
    function automatic step_t issue_step(input logic [31:0] pos, input logic [31:0] rem,
                                         input logic [31:0] done, input logic writing);
        step_t                s;
        logic [SOFS_W-1:0]    soff;
        logic [COUNT_W-1:0]   nsec;
        logic [CHUNK_W-1:0]   chunk;
        s     = '0;
        soff  = pos[SOFS_W-1:0];
        nsec  = '0;
        chunk = '0;
        s.res.lba           = pos[31:SECTOR_SHIFT];
        s.res.buffer_offset = done;
        if (soff == '0 && rem >= 32'(SECTOR_BYTES))
        begin
            if (rem[31:SECTOR_SHIFT] > 23'(MAX_SECTORS))
                nsec = COUNT_W'(MAX_SECTORS);
            else
                nsec = rem[SECTOR_SHIFT+COUNT_W-1:SECTOR_SHIFT];
            s.res.op           = writing ? OP_WRITE : OP_READ;
            s.res.sector_count = nsec;
            s.pend             = {nsec, {SECTOR_SHIFT{1'b0}}};
            s.phase            = PH_FULL;
        end
        else
        begin
            chunk = CHUNK_W'(SECTOR_BYTES) - {1'b0, soff};
            if ({22'd0, chunk} > rem)
                chunk = rem[CHUNK_W-1:0];
            s.res.op            = OP_READ;
            s.res.sector_count  = COUNT_W'(1);
            s.res.sector_offset = soff;
            s.res.chunk_bytes   = chunk;
            s.res.staged        = 1'b1;
            s.pend              = {{(PEND_W-CHUNK_W){1'b0}}, chunk};
            s.phase             = PH_SREAD;
        end
        return s;
    endfunction

endpackage

/* sv/bts_if.sv */
// Valid/ready channel interfaces for request/completion items and results.
// Depends on bts_pkg.
interface bts_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        is_write;
    logic [31:0] byte_offset;
    logic [31:0] byte_length;
    logic        status_ok;

    modport source (output valid, cmd, is_write, byte_offset, byte_length, status_ok,
                    input ready);
    modport sink   (input valid, cmd, is_write, byte_offset, byte_length, status_ok,
                    output ready);
endinterface

interface bts_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [bts_pkg::LBA_W-1:0]   lba;
    logic [bts_pkg::COUNT_W-1:0] sector_count;
    logic [31:0]                 buffer_offset;
    logic [bts_pkg::SOFS_W-1:0]  sector_offset;
    logic [bts_pkg::CHUNK_W-1:0] chunk_bytes;
    logic                        staged;
    logic [31:0]                 bytes_done;

    modport source (output valid, op, lba, sector_count, buffer_offset, sector_offset,
                    chunk_bytes, staged, bytes_done, input ready);
    modport sink   (input valid, op, lba, sector_count, buffer_offset, sector_offset,
                    chunk_bytes, staged, bytes_done, output ready);
endinterface

/* sv/byte_to_sector_request_splitter.sv */
// Byte to sector request splitter, top level.
// An accepted item passes through the input register, the step logic and then the result register.
// Throughput: one item per cycle, but an item that yields a result waits while the result
// register is full and not being drained. Result register drains independently of input side.
// Reset (rst_n, async low): idle, no disk, zero sectors, both registers empty.
module byte_to_sector_request_splitter (
    input  logic                             clk,
    input  logic                             rst_n,
    bts_in_if.sink                           req,
    bts_out_if.source                        res,
    input  logic                             cfg_we,
    input  logic [bts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bts_pkg::*;

    in_item_t  item_reg;
    logic      item_valid_reg;
    state_t    state_reg;
    state_t    state_next;
    cfg_t      cfg_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t step_res;
    logic      produce;
    logic      fire;

    bts_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .produce    (produce),
        .res        (step_res)
    );

    // An item that yields a result needs room in the result register.
    assign fire      = item_valid_reg && (!produce || !out_valid_reg || res.ready);
    assign req.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
            cfg_reg        <= '0;
        end
        else
        begin
            if (req.ready)
                item_valid_reg <= req.valid;
            if (fire && produce)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (fire)
                state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DISK_PRESENT:  cfg_reg.disk_present  <= cfg_data[0];
                    REG_TOTAL_SECTORS: cfg_reg.total_sectors <= cfg_data[LBA_W-1:0];
                    default:           cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.cmd         <= req.cmd;
            item_reg.is_write    <= req.is_write;
            item_reg.byte_offset <= req.byte_offset;
            item_reg.byte_length <= req.byte_length;
            item_reg.status_ok   <= req.status_ok;
        end
        if (fire && produce)
            out_reg <= step_res;
    end

    assign res.valid         = out_valid_reg;
    assign res.op            = out_reg.op;
    assign res.lba           = out_reg.lba;
    assign res.sector_count  = out_reg.sector_count;
    assign res.buffer_offset = out_reg.buffer_offset;
    assign res.sector_offset = out_reg.sector_offset;
    assign res.chunk_bytes   = out_reg.chunk_bytes;
    assign res.staged        = out_reg.staged;
    assign res.bytes_done    = out_reg.bytes_done;

endmodule

/* sv/bts_step.sv */
// Combinational step of the splitter: one item against the current transfer state.
// Produces the next state and at most one result. Depends on bts_pkg.
module bts_step (
    input  bts_pkg::in_item_t  item,
    input  bts_pkg::state_t    state,
    input  bts_pkg::cfg_t      cfg,
    output bts_pkg::state_t    state_next,
    output logic               produce,
    output bts_pkg::out_item_t res
);
    import bts_pkg::*;

    logic [31:0] cap_bytes;
    logic [32:0] req_end;
    logic [31:0] req_len;
    logic [31:0] done_adv;
    logic [31:0] pos_adv;
    logic [31:0] rem_adv;
    step_t       s;

    // Capacity in bytes fits 32 bits exactly (23-bit sectors times 512).
    assign cap_bytes  = {cfg.total_sectors, {SECTOR_SHIFT{1'b0}}};
    assign req_end    = {1'b0, item.byte_offset} + {1'b0, item.byte_length};
    assign req_len    = (req_end > {1'b0, cap_bytes}) ? cap_bytes - item.byte_offset
                                                       : item.byte_length;
    assign done_adv   = state.done + {{(32-PEND_W){1'b0}}, state.pend};
    assign pos_adv    = state.pos  + {{(32-PEND_W){1'b0}}, state.pend};
    assign rem_adv    = state.rem  - {{(32-PEND_W){1'b0}}, state.pend};

    always_comb
    begin
        state_next = state;
        produce    = 1'b0;
        s          = '0;
        if (item.cmd == CMD_REQUEST)
        begin
            if (state.phase == PH_IDLE)
            begin
                produce            = 1'b1;
                state_next.writing = item.is_write;
                state_next.pos     = item.byte_offset;
                state_next.done    = '0;
                state_next.rem     = '0;
                if (!cfg.disk_present || item.byte_offset >= cap_bytes || req_len == '0)
                    s = finish_step('0);
                else
                begin
                    state_next.rem = req_len;
                    s = issue_step(item.byte_offset, req_len, '0, item.is_write);
                end
                state_next.phase = s.phase;
                state_next.pend  = s.pend;
            end
        end
        else if (state.phase != PH_IDLE)
        begin
            produce = 1'b1;
            if (!item.status_ok)
                s = finish_step(state.done);
            else if (state.phase == PH_SREAD && state.writing)
            begin
                // read half of read-modify-write done; write the same sector back
                s = '0;
                s.res.op            = OP_WRITE;
                s.res.lba           = state.pos[31:SECTOR_SHIFT];
                s.res.sector_count  = COUNT_W'(1);
                s.res.buffer_offset = state.done;
                s.res.sector_offset = state.pos[SOFS_W-1:0];
                s.res.chunk_bytes   = state.pend[CHUNK_W-1:0];
                s.res.staged        = 1'b1;
                s.phase             = PH_SWRITE;
                s.pend              = state.pend;
            end
            else
            begin
                state_next.done = done_adv;
                state_next.pos  = pos_adv;
                state_next.rem  = rem_adv;
                if (rem_adv == '0)
                    s = finish_step(done_adv);
                else
                    s = issue_step(pos_adv, rem_adv, done_adv, state.writing);
            end
            state_next.phase = s.phase;
            state_next.pend  = s.pend;
        end
        res = s.res;
    end

endmodule

/* bench/bts_checker.sv */
// Scoreboard for the byte to sector request splitter: watches both channels and the
// register port, predicts every sector command or finish, and compares them in order.
// Depends on bts_pkg and the channel interfaces in bts_if.sv.
module bts_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    bts_in_if                                req,
    bts_out_if                               res,
    input  logic                             cfg_we,
    input  logic [bts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               failures,
    output int                               outstanding,
    output int                               accepted_items,
    output int                               active_items,
    output int                               checked_results,
    output logic                             busy
);
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // register copies
    logic              disk_on;
    logic [LBA_W-1:0]  disk_sectors;

    // transfer state
    phase_t            xfer_phase;
    logic              xfer_write;
    logic [31:0]       xfer_start;
    logic [31:0]       xfer_len;
    logic [31:0]       xfer_done;
    logic [PEND_W-1:0] credit;

    out_item_t         due_cmds[$];

    function automatic out_item_t finish_cmd();
        out_item_t r;
        r            = '0;
        r.op         = OP_FINISH;
        r.bytes_done = xfer_done;
        xfer_phase   = PH_IDLE;
        credit       = '0;
        return r;
    endfunction

    // Command at the current byte position: multi-sector when aligned with a whole
    // sector left, otherwise a one-sector staged read of the partial chunk.
    function automatic out_item_t issue_cmd();
        out_item_t   r;
        logic [31:0] pos;
        logic [31:0] want;
        logic [31:0] nsec;
        logic [31:0] chunk;
        r               = '0;
        pos             = xfer_start + xfer_done;
        want            = xfer_len - xfer_done;
        r.lba           = pos[31:SECTOR_SHIFT];
        r.buffer_offset = xfer_done;
        if (pos[SECTOR_SHIFT-1:0] == '0 && want >= SECTOR_BYTES)
        begin
            nsec = want >> SECTOR_SHIFT;
            if (nsec > MAX_SECTORS)
                nsec = MAX_SECTORS;
            credit         = PEND_W'(nsec << SECTOR_SHIFT);
            xfer_phase     = PH_FULL;
            r.op           = xfer_write ? OP_WRITE : OP_READ;
            r.sector_count = COUNT_W'(nsec);
        end
        else
        begin
            chunk = SECTOR_BYTES - pos[SECTOR_SHIFT-1:0];
            if (chunk > want)
                chunk = want;
            credit          = PEND_W'(chunk);
            xfer_phase      = PH_SREAD;
            r.op            = OP_READ;
            r.sector_count  = COUNT_W'(1);
            r.sector_offset = pos[SECTOR_SHIFT-1:0];
            r.chunk_bytes   = CHUNK_W'(chunk);
            r.staged        = 1'b1;
        end
        return r;
    endfunction

    // Returns 1 when the item yields a result, 0 when the block ignores it.
    function automatic bit predict_item(input in_item_t it, output out_item_t r);
        logic [32:0] cap;
        logic [31:0] len;
        logic [31:0] pos;
        r   = '0;
        cap = {1'b0, disk_sectors, {SECTOR_SHIFT{1'b0}}};
        len = it.byte_length;
        if (it.cmd == CMD_REQUEST)
        begin
            if (xfer_phase != PH_IDLE)
                return 0;
            xfer_write = it.is_write;
            xfer_start = it.byte_offset;
            xfer_done  = '0;
            xfer_len   = '0;
            if (!disk_on || {1'b0, it.byte_offset} >= cap)
            begin
                r = finish_cmd();
                return 1;
            end
            // clamp with a 33-bit sum so offset plus length cannot wrap
            if ({1'b0, it.byte_offset} + {1'b0, len} > cap)
                len = 32'(cap - {1'b0, it.byte_offset});
            if (len == '0)
            begin
                r = finish_cmd();
                return 1;
            end
            xfer_len = len;
            r = issue_cmd();
            return 1;
        end
        if (xfer_phase == PH_IDLE)
            return 0;
        if (!it.status_ok)
        begin
            r = finish_cmd();
            return 1;
        end
        // staged read of a write transfer: write the same sector back, no credit yet
        if (xfer_phase == PH_SREAD && xfer_write)
        begin
            pos             = xfer_start + xfer_done;
            xfer_phase      = PH_SWRITE;
            r.op            = OP_WRITE;
            r.lba           = pos[31:SECTOR_SHIFT];
            r.sector_count  = COUNT_W'(1);
            r.buffer_offset = xfer_done;
            r.sector_offset = pos[SECTOR_SHIFT-1:0];
            r.chunk_bytes   = CHUNK_W'(credit);
            r.staged        = 1'b1;
            return 1;
        end
        xfer_done = xfer_done + credit;
        credit    = '0;
        r = (xfer_done >= xfer_len) ? finish_cmd() : issue_cmd();
        return 1;
    endfunction

    function automatic string show(input out_item_t c);
        return $sformatf("op=%0d lba=%0d cnt=%0d buf=%0d sofs=%0d chunk=%0d stg=%0d done=%0d",
                         c.op, c.lba, c.sector_count, c.buffer_offset, c.sector_offset,
                         c.chunk_bytes, c.staged, c.bytes_done);
    endfunction

    function automatic string diff_fields(input out_item_t e, input out_item_t a);
        string s;
        s = "";
        if (a.op !== e.op)                       s = {s, " op"};
        if (a.lba !== e.lba)                     s = {s, " lba"};
        if (a.sector_count !== e.sector_count)   s = {s, " sector_count"};
        if (a.buffer_offset !== e.buffer_offset) s = {s, " buffer_offset"};
        if (a.sector_offset !== e.sector_offset) s = {s, " sector_offset"};
        if (a.chunk_bytes !== e.chunk_bytes)     s = {s, " chunk_bytes"};
        if (a.staged !== e.staged)               s = {s, " staged"};
        if (a.bytes_done !== e.bytes_done)       s = {s, " bytes_done"};
        return s;
    endfunction

    task automatic flag_error(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        in_item_t  it;
        out_item_t want;
        out_item_t got;
        string     bad;
        if (!rst_n)
        begin
            disk_on         = 1'b0;
            disk_sectors    = '0;
            xfer_phase      = PH_IDLE;
            xfer_write      = 1'b0;
            xfer_start      = '0;
            xfer_len        = '0;
            xfer_done       = '0;
            credit          = '0;
            due_cmds.delete();
            failures        = 0;
            accepted_items  = 0;
            active_items    = 0;
            checked_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DISK_PRESENT)
                    disk_on = cfg_data[0];
                else if (cfg_index == REG_TOTAL_SECTORS)
                    disk_sectors = cfg_data[LBA_W-1:0];
            end
            if (req.valid && req.ready)
            begin
                it = {req.cmd, req.is_write, req.byte_offset, req.byte_length, req.status_ok};
                accepted_items++;
                if (predict_item(it, want))
                begin
                    active_items++;
                    due_cmds.push_back(want);
                end
            end
            if (res.valid && res.ready)
            begin
                got = {res.op, res.lba, res.sector_count, res.buffer_offset,
                       res.sector_offset, res.chunk_bytes, res.staged, res.bytes_done};
                checked_results++;
                if (due_cmds.size() == 0)
                    flag_error($sformatf("unexpected result: %s", show(got)));
                else
                begin
                    want = due_cmds.pop_front();
                    bad  = diff_fields(want, got);
                    if (bad != "")
                        flag_error($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                             bad, show(want), show(got)));
                end
            end
        end
        outstanding = due_cmds.size();
        busy        = (xfer_phase != PH_IDLE);
    end

endmodule

/* bench/testbench.sv */
// Top of the splitter testbench: clock, reset, register writes, request and completion
// stimulus, output back-pressure and the verdict. Checking lives in bts_checker.
// Depends on bts_pkg, bts_if.sv, bts_checker.sv and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_XFER_CMDS = 40;
    localparam int PHASES        = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit          idle_en = 1'b1;
    bit          hold_request = 1'b0;
    logic [32:0] cap_bytes = '0;
    int          stall_cycles = 0;

    int   failures;
    int   outstanding;
    int   accepted_items;
    int   active_items;
    int   checked_results;
    logic busy;

    bts_in_if  req_ch ();
    bts_out_if res_ch ();

    byte_to_sector_request_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bts_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .res             (res_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .outstanding     (outstanding),
        .accepted_items  (accepted_items),
        .active_items    (active_items),
        .checked_results (checked_results),
        .busy            (busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: cycles with no handshake on either channel and no register write
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        int held;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
            end
            res_ch.ready <= !(idle_en && $urandom_range(0, 99) < 34);
        end
    end

    function automatic in_item_t make_request(input bit wr, input logic [31:0] ofs,
                                              input logic [31:0] len);
        in_item_t it;
        it.cmd         = CMD_REQUEST;
        it.is_write    = wr;
        it.byte_offset = ofs;
        it.byte_length = len;
        it.status_ok   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t make_completion(input bit ok);
        in_item_t it;
        it.cmd         = CMD_COMPLETION;
        it.is_write    = 1'($urandom_range(0, 1));
        it.byte_offset = $urandom;
        it.byte_length = $urandom;
        it.status_ok   = ok;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // valid is left high so back-to-back items need no second assignment in a step.
    task automatic send_item(input in_item_t it);
        while (idle_en && $urandom_range(0, 99) < 34)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= it.cmd;
        req_ch.is_write    <= it.is_write;
        req_ch.byte_offset <= it.byte_offset;
        req_ch.byte_length <= it.byte_length;
        req_ch.status_ok   <= it.status_ok;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic complete_all();
        while (busy)
            send_item(make_completion(1'b1));
    endtask

    // drain everything in flight, then allow for the pipeline before touching registers
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input bit present, input logic [LBA_W-1:0] sectors);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DISK_PRESENT;
        cfg_data  <= CFG_DATA_W'(present);
        @(negedge clk);
        cfg_index <= REG_TOTAL_SECTORS;
        cfg_data  <= sectors;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        cap_bytes = {1'b0, sectors, {SECTOR_SHIFT{1'b0}}};
    endtask

    // One request followed by completions until the transfer ends; a few failures,
    // requests while busy and completions while idle are mixed in.
    task automatic random_transfer();
        logic [31:0] ofs;
        logic [31:0] len;
        logic [31:0] last_ofs;
        bit          ok;
        int          n;
        last_ofs = 32'(cap_bytes - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ofs = (cap_bytes == 0) ? 32'd0 : $urandom_range(0, last_ofs);
            4, 5:       ofs = (cap_bytes == 0) ? 32'd0 :
                              ($urandom_range(0, last_ofs) & ~32'(SECTOR_BYTES - 1));
            6:          ofs = (cap_bytes > 2048) ?
                              32'(cap_bytes - $urandom_range(1, 2048)) : 32'(cap_bytes);
            7:          ofs = 32'(cap_bytes);
            default:    ofs = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(1, 1536);
            5, 6:          len = $urandom_range(1, 3 * MAX_SECTORS * SECTOR_BYTES);
            7:             len = $urandom_range(1, 8) * SECTOR_BYTES;
            8:             len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default:       len = $urandom;
        endcase
        send_item(make_request(1'($urandom_range(0, 1)), ofs, len));
        n = 0;
        while (busy)
        begin
            n++;
            ok = (n < MAX_XFER_CMDS) && ($urandom_range(0, 99) >= 4);
            if ($urandom_range(0, 19) == 0)
                send_item(make_request(1'($urandom_range(0, 1)), $urandom, $urandom));
            send_item(make_completion(ok));
        end
        if ($urandom_range(0, 9) == 0)
            send_item(make_completion(1'($urandom_range(0, 1))));
    endtask

    initial
    begin : stimulus
        int               goal;
        int               quota;
        bit               present;
        logic [LBA_W-1:0] sectors;
        logic [31:0]      last_byte;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_REQUEST;
        req_ch.is_write    = 1'b0;
        req_ch.byte_offset = '0;
        req_ch.byte_length = '0;
        req_ch.status_ok   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no disk attached: requests finish with zero bytes
        configure(1'b0, LBA_W'(1000));
        send_item(make_request(1'b0, 32'd0, 32'd4096));
        send_item(make_request(1'b1, 32'd100, 32'd1));
        // completion with nothing outstanding is dropped
        send_item(make_completion(1'b1));

        // zero capacity: any offset is past the end
        configure(1'b1, '0);
        send_item(make_request(1'b0, 32'd0, 32'd512));

        configure(1'b1, {LBA_W{1'b1}});
        last_byte = 32'(cap_bytes);
        // one aligned sector
        send_item(make_request(1'b0, 32'd0, 32'd512));
        complete_all();
        // zero length
        send_item(make_request(1'b1, 32'd0, 32'd0));
        // partial sector read
        send_item(make_request(1'b0, 32'd100, 32'd50));
        complete_all();
        // partial write across a sector boundary: read, write back, twice
        send_item(make_request(1'b1, 32'd300, 32'd300));
        complete_all();
        // whole disk read at the command size limit, request while busy, then failure
        send_item(make_request(1'b0, 32'd0, 32'hFFFF_FFFF));
        send_item(make_completion(1'b1));
        send_item(make_request(1'b1, 32'd512, 32'd512));
        send_item(make_completion(1'b0));
        // wide clamp near the end of the disk, staged read fails
        send_item(make_request(1'b1, last_byte - 32'd10, 32'hFFFF_FFFF));
        send_item(make_completion(1'b0));
        // offsets at and beyond capacity
        send_item(make_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_request(1'b0, last_byte, 32'd1));

        goal = active_items;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin present = 1'b1; sectors = {LBA_W{1'b1}};            quota = 350; end
                1:       begin present = 1'b1; sectors = LBA_W'(1);                quota = 250; end
                2:       begin present = 1'b1; sectors = LBA_W'($urandom_range(2, 64));
                               quota = 350; end
                3:       begin present = 1'b0; sectors = LBA_W'($urandom);         quota = 100; end
                4:       begin present = 1'b1;
                               sectors = LBA_W'($urandom_range(1, (1 << LBA_W) - 1));
                               quota = 450; end
                default: begin present = 1'b1; sectors = LBA_W'(300);              quota = 380; end
            endcase
            configure(present, sectors);
            // one phase runs without any idle cycles on either side
            idle_en = (p != 4);
            if (p == 0)
                hold_request = 1'b1;
            goal += quota;
            while (active_items < goal)
                random_transfer();
        end

        idle_en = 1'b1;
        settle();
        repeat (4) @(posedge clk);
        $display("Sent %0d items (%0d acted on), checked %0d commands and finishes",
                 accepted_items, active_items, checked_results);
        $display("over nine disk settings, with one %0d-cycle output hold-off", HOLD_CYCLES);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
